### rtl/ssc_pkg.sv
// Shared constants, types and angle helpers for the Stanley steering controller.
package ssc_pkg;

  localparam int PATH_DEPTH_DEF    = 256;
  localparam int SEARCH_WINDOW_DEF = 32;

  localparam int CORDIC_W     = 56;
  localparam int ANG_W        = 24;
  localparam int CORDIC_STEPS = 16;

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t PI_Q16      = 24'sd205887;
  localparam ang_t HALF_PI_Q16 = 24'sd102944;
  localparam ang_t TWO_PI_Q16  = 24'sd411775;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 56'sd39797;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_STEER  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] REG_AXLE  = 2'd0;
  localparam logic [1:0] REG_FLOOR = 2'd1;
  localparam logic [1:0] REG_GAIN  = 2'd2;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_req_t;

  function automatic ang_t arc_at(input logic [3:0] i);
    ang_t a;
    case (i)
      4'd0:    a = 24'sd51472;
      4'd1:    a = 24'sd30386;
      4'd2:    a = 24'sd16055;
      4'd3:    a = 24'sd8150;
      4'd4:    a = 24'sd4091;
      4'd5:    a = 24'sd2047;
      4'd6:    a = 24'sd1024;
      4'd7:    a = 24'sd512;
      4'd8:    a = 24'sd256;
      4'd9:    a = 24'sd128;
      4'd10:   a = 24'sd64;
      4'd11:   a = 24'sd32;
      4'd12:   a = 24'sd16;
      4'd13:   a = 24'sd8;
      4'd14:   a = 24'sd4;
      default: a = 24'sd2;
    endcase
    return a;
  endfunction

  function automatic ang_t wrap_angle(input ang_t a);
    ang_t r;
    if (a > PI_Q16) begin
      r = a - TWO_PI_Q16;
    end else if (a < -PI_Q16) begin
      r = a + TWO_PI_Q16;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

### rtl/ssc_if.sv
// Input and result channel interfaces of the Stanley steering controller.
interface ssc_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic signed [31:0] waypoint_x;
  logic signed [31:0] waypoint_y;
  logic signed [31:0] car_x;
  logic signed [31:0] car_y;
  logic signed [15:0] car_heading;
  logic signed [15:0] car_speed;

  modport source (output valid, cmd, waypoint_x, waypoint_y, car_x, car_y, car_heading,
                  car_speed, input ready);
  modport sink (input valid, cmd, waypoint_x, waypoint_y, car_x, car_y, car_heading,
                car_speed, output ready);
endinterface

interface ssc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] steer_angle;
  logic        [7:0]  matched_index;
  logic               path_is_empty;
  logic               table_full;

  modport source (output valid, steer_angle, matched_index, path_is_empty, table_full,
                  input ready);
  modport sink (input valid, steer_angle, matched_index, path_is_empty, table_full,
                output ready);
endinterface

### rtl/ssc_path_mem.sv
// Waypoint store: x and y arrays, one write port, one registered read port.
module ssc_path_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wx,
  input  logic signed [31:0] wy,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rx,
  output logic signed [31:0] ry
);

  logic signed [31:0] mem_x [DEPTH];
  logic signed [31:0] mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
  end

endmodule

### rtl/ssc_cordic.sv
// Shared iterative CORDIC: rotation for sin/cos, vectoring for atan2, one step a cycle.
module ssc_cordic
  import ssc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cordic_req_t                req,
  input  logic signed [CORDIC_W-1:0] x_in,
  input  logic signed [CORDIC_W-1:0] y_in,
  input  ang_t                       ang_in,
  output logic                       done,
  output logic signed [CORDIC_W-1:0] x_out,
  output logic signed [CORDIC_W-1:0] y_out,
  output ang_t                       z_out
);

  logic                       busy_r;
  logic                       done_r;
  logic                       vec_r;
  logic                       neg_r;
  logic                       zero_r;
  logic [3:0]                 step_r;
  logic signed [CORDIC_W-1:0] x_r;
  logic signed [CORDIC_W-1:0] y_r;
  ang_t                       z_r;

  ang_t                       a_wrap;
  ang_t                       a_fold;
  logic                       a_neg;
  logic                       sigma;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;

  always_comb begin
    a_wrap = wrap_angle(wrap_angle(ang_in));
    a_neg  = 1'b0;
    a_fold = a_wrap;
    if (a_wrap > HALF_PI_Q16) begin
      a_fold = a_wrap - PI_Q16;
      a_neg  = 1'b1;
    end else if (a_wrap < -HALF_PI_Q16) begin
      a_fold = a_wrap + PI_Q16;
      a_neg  = 1'b1;
    end
    sigma = vec_r ? y_r[CORDIC_W-1] : ~z_r[ANG_W-1];
    xs    = x_r >>> step_r;
    ys    = y_r >>> step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        vec_r  <= req.vec;
        if (req.vec) begin
          neg_r  <= 1'b0;
          zero_r <= (x_in == '0) && (y_in == '0);
          if (x_in < 0) begin
            z_r <= (y_in >= 0) ? PI_Q16 : -PI_Q16;
            x_r <= -x_in;
            y_r <= -y_in;
          end else begin
            z_r <= '0;
            x_r <= x_in;
            y_r <= y_in;
          end
        end else begin
          neg_r  <= a_neg;
          zero_r <= 1'b0;
          z_r    <= a_fold;
          x_r    <= CORDIC_GAIN;
          y_r    <= '0;
        end
      end else if (busy_r) begin
        if (sigma) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - arc_at(step_r);
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + arc_at(step_r);
        end
        step_r <= step_r + 4'd1;
        if (step_r == 4'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign x_out = neg_r ? -x_r : x_r;
  assign y_out = neg_r ? -y_r : y_r;
  assign z_out = zero_r ? '0 : z_r;

endmodule

### rtl/stanley_steering_controller.sv
// Top level of the Stanley steering controller: sequencer, scan pipeline and config.
//
//  channel  | dir | transfer when          | payload
//  ---------+-----+------------------------+----------------------------------------------
//  in_ch    | in  | valid && ready         | cmd, waypoint_x/y, car_x/y, heading, speed
//  out_ch   | out | valid && ready         | steer_angle, matched_index, empty, full
//  cfg_*    | in  | cfg_we                 | cfg_index, cfg_data
//
// Clear, append and unused commands, and steering on an empty path, go straight
// to the output stage. Steering runs four 16-step passes of the CORDIC unit and a
// scan of one stored point a cycle through the memory read port.
// Synchronous active-low reset empties the path; no clearing pass is needed.
// A result waits in the output register while the next item is taken.
module stanley_steering_controller
  import ssc_pkg::*;
#(
  parameter int PATH_DEPTH    = PATH_DEPTH_DEF,
  parameter int SEARCH_WINDOW = SEARCH_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ssc_in_if.sink      in_ch,
  ssc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int CW = AW + 1;
  localparam int EW = CW + 9;

  typedef enum logic [4:0] {
    S_IDLE, S_ROT1, S_WROT1, S_PROJ, S_FRONT, S_SCAN, S_DRAIN, S_RDPV, S_RDNX,
    S_RDBEST, S_YAW, S_WVEC1, S_ROT2, S_WROT2, S_LAT1, S_LAT2, S_GAIN, S_VEC2,
    S_WVEC2, S_PUSH
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      start_r, start_nxt;
  logic [20:0]        axle_r;
  logic [14:0]        floor_r;
  logic [15:0]        gain_r;
  logic signed [31:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [18:0] hd_r, hd_nxt;
  logic signed [15:0] speed_r, speed_nxt;
  logic signed [17:0] hc_r, hc_nxt, hs_r, hs_nxt;
  logic signed [39:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [31:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic [AW-1:0]      scan_r, scan_nxt;
  logic [CW-1:0]      end_r, end_nxt;
  logic               rdv_r, rdv_nxt;
  logic [AW-1:0]      rdi_r, rdi_nxt;
  logic               sqv_r, sqv_nxt;
  logic [AW-1:0]      sqi_r, sqi_nxt;
  logic [61:0]        sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [63:0]        best_r, best_nxt;
  logic [AW-1:0]      bi_r, bi_nxt;
  logic signed [31:0] pvx_r, pvx_nxt, pvy_r, pvy_nxt;
  logic signed [31:0] nxx_r, nxx_nxt, nxy_r, nxy_nxt;
  logic signed [31:0] bx_r, bx_nxt, by_r, by_nxt;
  ang_t               yaw_r, yaw_nxt, he_r, he_nxt;
  logic signed [17:0] yc_r, yc_nxt, ys_r, ys_nxt;
  logic signed [50:0] la_r, la_nxt, lb_r, lb_nxt;
  logic signed [35:0] elat_r, elat_nxt;
  logic signed [52:0] gp_r, gp_nxt;
  logic [16:0]        guard_r, guard_nxt;
  logic signed [14:0] res_steer_r, res_steer_nxt;
  logic [AW-1:0]      res_idx_r, res_idx_nxt;
  logic               full_r, full_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [14:0] o_steer_r, o_steer_nxt;
  logic [7:0]         o_idx_r, o_idx_nxt;
  logic               o_empty_r, o_empty_nxt;
  logic               o_full_r, o_full_nxt;

  logic                       in_fire;
  logic                       mem_we;
  logic [AW-1:0]              mem_raddr;
  logic signed [31:0]         mem_rx, mem_ry;
  cordic_req_t                cor_req;
  logic signed [CORDIC_W-1:0] cor_xin, cor_yin, cor_xout, cor_yout;
  ang_t                       cor_ang, cor_z;
  logic                       cor_done;

  logic signed [32:0] dmx, dmy, dxp, dyp, dxb, dyb;
  logic [32:0]        abx, aby;
  logic [30:0]        mgx, mgy;
  logic [62:0]        dsum;
  logic [AW-1:0]      st, pv, nx;
  logic [EW-1:0]      endw;
  logic signed [39:0] fxs, fys;
  logic signed [51:0] ldiff;
  logic [16:0]        spd_abs;
  logic signed [25:0] delta;
  logic signed [22:0] steer_w;
  logic [AW+7:0]      idx_ext;

  ssc_path_mem #(.DEPTH(PATH_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wx    (in_ch.waypoint_x),
    .wy    (in_ch.waypoint_y),
    .raddr (mem_raddr),
    .rx    (mem_rx),
    .ry    (mem_ry)
  );

  ssc_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (cor_req),
    .x_in   (cor_xin),
    .y_in   (cor_yin),
    .ang_in (cor_ang),
    .done   (cor_done),
    .x_out  (cor_xout),
    .y_out  (cor_yout),
    .z_out  (cor_z)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign mem_we      = in_fire && (in_ch.cmd == CMD_APPEND) && (count_r < CW'(PATH_DEPTH));

  always_comb begin
    dmx  = {mem_rx[31], mem_rx} - {fx_r[31], fx_r};
    dmy  = {mem_ry[31], mem_ry} - {fy_r[31], fy_r};
    abx  = dmx[32] ? 33'(-dmx) : 33'(dmx);
    aby  = dmy[32] ? 33'(-dmy) : 33'(dmy);
    mgx  = (abx > 33'h07FFFFFFF) ? 31'h7FFFFFFF : abx[30:0];
    mgy  = (aby > 33'h07FFFFFFF) ? 31'h7FFFFFFF : aby[30:0];
    dsum = {1'b0, sqx_r} + {1'b0, sqy_r};

    st   = ({1'b0, start_r} >= count_r) ? '0 : start_r;
    endw = EW'(st) + EW'(SEARCH_WINDOW);
    pv   = (bi_r != '0) ? bi_r - 1'b1 : '0;
    nx   = (({1'b0, bi_r} + 1'b1) < count_r) ? bi_r + 1'b1 : AW'(count_r - 1'b1);

    fxs  = 40'(cx_r) + (px_r >>> 16);
    fys  = 40'(cy_r) + (py_r >>> 16);

    dxp  = {nxx_r[31], nxx_r} - {pvx_r[31], pvx_r};
    dyp  = {nxy_r[31], nxy_r} - {pvy_r[31], pvy_r};
    dxb  = {fx_r[31], fx_r} - {bx_r[31], bx_r};
    dyb  = {fy_r[31], fy_r} - {by_r[31], by_r};

    ldiff   = {lb_r[50], lb_r} - {la_r[50], la_r};
    spd_abs = speed_r[15] ? 17'(-{speed_r[15], speed_r}) : 17'({speed_r[15], speed_r});
    delta   = -(26'(he_r) + 26'(cor_z));
    steer_w = 23'((delta + 26'sd4) >>> 3);
    idx_ext = {8'd0, res_idx_r};

    case (state_r)
      S_SCAN:   mem_raddr = scan_r;
      S_RDPV:   mem_raddr = pv;
      S_RDNX:   mem_raddr = nx;
      default:  mem_raddr = bi_r;
    endcase

    cor_req = '0;
    cor_xin = '0;
    cor_yin = '0;
    cor_ang = '0;
    case (state_r)
      S_ROT1: begin
        cor_req.start = 1'b1;
        cor_ang       = ANG_W'(hd_r);
      end
      S_YAW: begin
        cor_req = '{start: 1'b1, vec: 1'b1};
        cor_xin = CORDIC_W'(dxp);
        cor_yin = CORDIC_W'(dyp);
      end
      S_ROT2: begin
        cor_req.start = 1'b1;
        cor_ang       = yaw_r;
      end
      S_VEC2: begin
        cor_req = '{start: 1'b1, vec: 1'b1};
        cor_xin = {{(CORDIC_W-33){1'b0}}, guard_r, 16'd0};
        cor_yin = CORDIC_W'(gp_r);
      end
      default: begin
        cor_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    start_nxt     = start_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    hd_nxt        = hd_r;
    speed_nxt     = speed_r;
    hc_nxt        = hc_r;
    hs_nxt        = hs_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    scan_nxt      = scan_r;
    end_nxt       = end_r;
    rdv_nxt       = 1'b0;
    rdi_nxt       = rdi_r;
    sqv_nxt       = rdv_r;
    sqi_nxt       = rdi_r;
    sqx_nxt       = 62'(mgx) * 62'(mgx);
    sqy_nxt       = 62'(mgy) * 62'(mgy);
    best_nxt      = best_r;
    bi_nxt        = bi_r;
    pvx_nxt       = pvx_r;
    pvy_nxt       = pvy_r;
    nxx_nxt       = nxx_r;
    nxy_nxt       = nxy_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    yaw_nxt       = yaw_r;
    he_nxt        = he_r;
    yc_nxt        = yc_r;
    ys_nxt        = ys_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    elat_nxt      = elat_r;
    gp_nxt        = gp_r;
    guard_nxt     = guard_r;
    res_steer_nxt = res_steer_r;
    res_idx_nxt   = res_idx_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_steer_nxt   = o_steer_r;
    o_idx_nxt     = o_idx_r;
    o_empty_nxt   = o_empty_r;
    o_full_nxt    = o_full_r;

    if (sqv_r && ({1'b0, dsum} < best_r)) begin
      best_nxt = {1'b0, dsum};
      bi_nxt   = sqi_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_steer_nxt = '0;
          res_idx_nxt   = '0;
          full_nxt      = 1'b0;
          cx_nxt        = in_ch.car_x;
          cy_nxt        = in_ch.car_y;
          hd_nxt        = {in_ch.car_heading, 3'b000};
          speed_nxt     = in_ch.car_speed;
          state_nxt     = S_PUSH;
          case (in_ch.cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
              start_nxt = '0;
            end
            CMD_APPEND: begin
              if (mem_we) begin
                count_nxt = count_r + 1'b1;
              end else begin
                full_nxt = 1'b1;
              end
            end
            CMD_STEER: begin
              if (count_r != '0) begin
                state_nxt = S_ROT1;
              end
            end
            default: begin
              state_nxt = S_PUSH;
            end
          endcase
        end
      end
      S_ROT1: state_nxt = S_WROT1;
      S_WROT1: begin
        if (cor_done) begin
          hc_nxt    = cor_xout[17:0];
          hs_nxt    = cor_yout[17:0];
          state_nxt = S_PROJ;
        end
      end
      S_PROJ: begin
        px_nxt    = $signed({1'b0, axle_r}) * hc_r;
        py_nxt    = $signed({1'b0, axle_r}) * hs_r;
        state_nxt = S_FRONT;
      end
      S_FRONT: begin
        fx_nxt    = (fxs > 40'sh007FFFFFFF) ? 32'sh7FFFFFFF :
                    (fxs < -40'sh0080000000) ? -32'sh80000000 : fxs[31:0];
        fy_nxt    = (fys > 40'sh007FFFFFFF) ? 32'sh7FFFFFFF :
                    (fys < -40'sh0080000000) ? -32'sh80000000 : fys[31:0];
        scan_nxt  = st;
        end_nxt   = (endw > EW'(count_r)) ? count_r : endw[CW-1:0];
        best_nxt  = '1;
        bi_nxt    = st;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rdv_nxt = 1'b1;
        rdi_nxt = scan_r;
        if (({1'b0, scan_r} + 1'b1) == end_r) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!rdv_r && !sqv_r) begin
          start_nxt = bi_r;
          state_nxt = S_RDPV;
        end
      end
      S_RDPV: state_nxt = S_RDNX;
      S_RDNX: begin
        pvx_nxt   = mem_rx;
        pvy_nxt   = mem_ry;
        state_nxt = S_RDBEST;
      end
      S_RDBEST: begin
        nxx_nxt   = mem_rx;
        nxy_nxt   = mem_ry;
        state_nxt = S_YAW;
      end
      S_YAW: begin
        bx_nxt    = mem_rx;
        by_nxt    = mem_ry;
        state_nxt = S_WVEC1;
      end
      S_WVEC1: begin
        if (cor_done) begin
          yaw_nxt   = cor_z;
          he_nxt    = wrap_angle(wrap_angle(ANG_W'(hd_r) - cor_z));
          state_nxt = S_ROT2;
        end
      end
      S_ROT2: state_nxt = S_WROT2;
      S_WROT2: begin
        if (cor_done) begin
          yc_nxt    = cor_xout[17:0];
          ys_nxt    = cor_yout[17:0];
          state_nxt = S_LAT1;
        end
      end
      S_LAT1: begin
        la_nxt    = ys_r * dxb;
        lb_nxt    = yc_r * dyb;
        state_nxt = S_LAT2;
      end
      S_LAT2: begin
        elat_nxt  = ldiff[51:16];
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        gp_nxt    = $signed({1'b0, gain_r}) * elat_r;
        guard_nxt = (spd_abs < {2'b00, floor_r}) ? {2'b00, floor_r} : spd_abs;
        state_nxt = S_VEC2;
      end
      S_VEC2: state_nxt = S_WVEC2;
      S_WVEC2: begin
        if (cor_done) begin
          res_steer_nxt = (steer_w > 23'sd8192) ? 15'sd8192 :
                          (steer_w < -23'sd8192) ? -15'sd8192 : steer_w[14:0];
          res_idx_nxt   = bi_r;
          state_nxt     = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_steer_nxt   = res_steer_r;
          o_idx_nxt     = idx_ext[7:0];
          o_empty_nxt   = (count_r == '0);
          o_full_nxt    = full_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      start_r     <= '0;
      axle_r      <= 21'd163840;
      floor_r     <= 15'd256;
      gain_r      <= 16'd256;
      rdv_r       <= 1'b0;
      sqv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      rdv_r       <= rdv_nxt;
      sqv_r       <= sqv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_AXLE:  axle_r  <= cfg_data;
          REG_FLOOR: floor_r <= cfg_data[14:0];
          REG_GAIN:  gain_r  <= cfg_data[15:0];
          default:   axle_r  <= axle_r;
        endcase
      end
    end
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    hd_r        <= hd_nxt;
    speed_r     <= speed_nxt;
    hc_r        <= hc_nxt;
    hs_r        <= hs_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    fx_r        <= fx_nxt;
    fy_r        <= fy_nxt;
    scan_r      <= scan_nxt;
    end_r       <= end_nxt;
    rdi_r       <= rdi_nxt;
    sqi_r       <= sqi_nxt;
    sqx_r       <= sqx_nxt;
    sqy_r       <= sqy_nxt;
    best_r      <= best_nxt;
    bi_r        <= bi_nxt;
    pvx_r       <= pvx_nxt;
    pvy_r       <= pvy_nxt;
    nxx_r       <= nxx_nxt;
    nxy_r       <= nxy_nxt;
    bx_r        <= bx_nxt;
    by_r        <= by_nxt;
    yaw_r       <= yaw_nxt;
    he_r        <= he_nxt;
    yc_r        <= yc_nxt;
    ys_r        <= ys_nxt;
    la_r        <= la_nxt;
    lb_r        <= lb_nxt;
    elat_r      <= elat_nxt;
    gp_r        <= gp_nxt;
    guard_r     <= guard_nxt;
    res_steer_r <= res_steer_nxt;
    res_idx_r   <= res_idx_nxt;
    full_r      <= full_nxt;
    o_steer_r   <= o_steer_nxt;
    o_idx_r     <= o_idx_nxt;
    o_empty_r   <= o_empty_nxt;
    o_full_r    <= o_full_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.steer_angle   = o_steer_r;
  assign out_ch.matched_index = o_idx_r;
  assign out_ch.path_is_empty = o_empty_r;
  assign out_ch.table_full    = o_full_r;

endmodule

### tb/ssc_checker.sv
// Checker for the Stanley steering controller: predicts results and compares transfers.
`timescale 1ns / 1ps
module ssc_checker
  import ssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ssc_in_if           mon_in,
  ssc_out_if          mon_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic signed [14:0] steer;
    logic [7:0]         idx;
    logic               empty;
    logic               full;
  } steer_result_t;

  localparam longint PI_R     = 205887;
  localparam longint HALF_PI  = 102944;
  localparam longint TWO_PI   = 411775;
  localparam int     DEPTH    = 256;
  localparam int     WINDOW   = 32;

  longint        arc_tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2};
  longint        way_x [DEPTH];
  longint        way_y [DEPTH];
  int unsigned   n_points;
  int unsigned   scan_from;
  longint        axle_len;
  longint        spd_floor;
  longint        xgain;
  steer_result_t results_due[$];

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned abs_clip(input longint d);
    longint unsigned m;
    m = (d < 0) ? -d : d;
    return (m > 64'd2147483647) ? 64'd2147483647 : m;
  endfunction

  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, t;
    bit flip;
    x = 39797;
    y = 0;
    flip = 0;
    for (int k = 0; k < 2; k++) begin
      if (ang > PI_R) ang -= TWO_PI;
      else if (ang < -PI_R) ang += TWO_PI;
    end
    if (ang > HALF_PI) begin
      ang -= PI_R;
      flip = 1;
    end else if (ang < -HALF_PI) begin
      ang += PI_R;
      flip = 1;
    end
    z = ang;
    for (int k = 0; k < 16; k++) begin
      if (z >= 0) begin
        t = x - (y >>> k);
        y = y + (x >>> k);
        z -= arc_tab[k];
      end else begin
        t = x + (y >>> k);
        y = y - (x >>> k);
        z += arc_tab[k];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint vec_angle(input longint y, input longint x);
    longint z, t;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_R : -PI_R;
      x = -x;
      y = -y;
    end
    for (int k = 0; k < 16; k++) begin
      if (y >= 0) begin
        t = x + (y >>> k);
        y = y - (x >>> k);
        z += arc_tab[k];
      end else begin
        t = x - (y >>> k);
        y = y + (x >>> k);
        z -= arc_tab[k];
      end
      x = t;
    end
    return z;
  endfunction

  function automatic steer_result_t predict_steer(input logic [1:0] cmd,
      input logic signed [31:0] wx, input logic signed [31:0] wy,
      input logic signed [31:0] cx, input logic signed [31:0] cy,
      input logic signed [15:0] hd_in, input logic signed [15:0] sp_in);
    steer_result_t r;
    longint hd, hc, hs, fx, fy, yc, ys, yaw, herr, elat, guard, delta, steer;
    longint unsigned best, ax, ay, d2;
    int unsigned st, en, bi, pv, nx;
    steer = 0;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      n_points = 0;
      scan_from = 0;
    end else if (cmd == CMD_APPEND) begin
      if (n_points < DEPTH) begin
        way_x[n_points] = wx;
        way_y[n_points] = wy;
        n_points++;
      end else begin
        r.full = 1'b1;
      end
    end else if (cmd == CMD_STEER && n_points > 0) begin
      hd = longint'(hd_in) * 8;
      rotate(hd, hc, hs);
      fx = clip32(longint'(cx) + ((axle_len * hc) >>> 16));
      fy = clip32(longint'(cy) + ((axle_len * hs) >>> 16));
      st = (scan_from >= n_points) ? 0 : scan_from;
      en = st + WINDOW;
      if (en > n_points) en = n_points;
      bi = st;
      best = '1;
      for (int unsigned i = st; i < en; i++) begin
        ax = abs_clip(way_x[i] - fx);
        ay = abs_clip(way_y[i] - fy);
        d2 = ax * ax + ay * ay;
        if (d2 < best) begin
          best = d2;
          bi = i;
        end
      end
      scan_from = bi;
      pv = (bi > 0) ? bi - 1 : 0;
      nx = (bi + 1 < n_points) ? bi + 1 : n_points - 1;
      yaw = vec_angle(way_y[nx] - way_y[pv], way_x[nx] - way_x[pv]);
      herr = hd - yaw;
      for (int k = 0; k < 2; k++) begin
        if (herr > PI_R) herr -= TWO_PI;
        else if (herr < -PI_R) herr += TWO_PI;
      end
      rotate(yaw, yc, ys);
      elat = (-ys * (fx - way_x[bi]) + yc * (fy - way_y[bi])) >>> 16;
      guard = (sp_in < 0) ? -longint'(sp_in) : longint'(sp_in);
      if (guard < spd_floor) guard = spd_floor;
      delta = -(herr + vec_angle(xgain * elat, guard * 65536));
      steer = (delta + 4) >>> 3;
      if (steer > 8192) steer = 8192;
      if (steer < -8192) steer = -8192;
      r.idx = bi[7:0];
    end
    r.steer = steer[14:0];
    r.empty = (n_points == 0);
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial begin
    fails = 0;
  end

  assign pending = results_due.size();

  always @(posedge clk) begin
    steer_result_t e;
    if (!rst_n) begin
      n_points  <= 0;
      scan_from <= 0;
      axle_len  <= 163840;
      spd_floor <= 256;
      xgain     <= 256;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_AXLE:  axle_len  <= longint'(cfg_data);
          REG_FLOOR: spd_floor <= longint'(cfg_data[14:0]);
          REG_GAIN:  xgain     <= longint'(cfg_data[15:0]);
          default: ;
        endcase
      end
      if (mon_in.valid && mon_in.ready) begin
        results_due.push_back(predict_steer(mon_in.cmd, mon_in.waypoint_x, mon_in.waypoint_y,
            mon_in.car_x, mon_in.car_y, mon_in.car_heading, mon_in.car_speed));
      end
      if (mon_out.valid && mon_out.ready) begin
        if (results_due.size() == 0) begin
          report("unexpected transfer", 1, 0);
        end else begin
          e = results_due.pop_front();
          if (mon_out.steer_angle !== e.steer)
            report("steer_angle", mon_out.steer_angle, e.steer);
          if (mon_out.matched_index !== e.idx)
            report("matched_index", mon_out.matched_index, e.idx);
          if (mon_out.path_is_empty !== e.empty)
            report("path_is_empty", mon_out.path_is_empty, e.empty);
          if (mon_out.table_full !== e.full)
            report("table_full", mon_out.table_full, e.full);
        end
      end
    end
  end

endmodule

### tb/tb_top.sv
// Testbench top for the Stanley steering controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import ssc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int N_ITEMS     = 1250;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [20:0] cfg_data;
  int          fails;
  int          pending;
  int          sent;
  int          idle_cycles;
  int          rx_cycle;
  bit          busy_stretch;
  longint      path_x [256];
  longint      path_y [256];
  int          path_len;

  ssc_in_if  in_ch ();
  ssc_out_if out_ch ();

  stanley_steering_controller i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ssc_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .mon_in   (in_ch),
    .mon_out  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fails    (fails),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= 6000 && rx_cycle < 6400) begin
        out_ch.ready <= 1'b0;
      end else if (rx_cycle >= 12000 && rx_cycle < 20000) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] wx,
      input logic signed [31:0] wy, input logic signed [31:0] cx, input logic signed [31:0] cy,
      input logic signed [15:0] hd, input logic signed [15:0] sp);
    if (!busy_stretch && $urandom_range(0, 99) < 35) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.waypoint_x  <= wx;
    in_ch.waypoint_y  <= wy;
    in_ch.car_x       <= cx;
    in_ch.car_y       <= cy;
    in_ch.car_heading <= hd;
    in_ch.car_speed   <= sp;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 21'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned axle, input int unsigned flr,
      input int unsigned gain);
    drain();
    write_reg(REG_AXLE, axle);
    write_reg(REG_FLOOR, flr);
    write_reg(REG_GAIN, gain);
  endtask

  function automatic logic signed [15:0] rand_heading();
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  task automatic append_pt(input longint x, input longint y);
    send_item(CMD_APPEND, 32'(x), 32'(y), $urandom, $urandom, rand_heading(), 16'($urandom));
    if (path_len < 256) begin
      path_x[path_len] = x;
      path_y[path_len] = y;
      path_len++;
    end
  endtask

  task automatic clear_path();
    send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, rand_heading(),
              16'($urandom));
    path_len = 0;
  endtask

  task automatic build_path(input int n);
    longint x, y;
    x = longint'($signed($urandom_range(0, 131072000))) - 65536000;
    y = longint'($signed($urandom_range(0, 131072000))) - 65536000;
    clear_path();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) != 0) begin
        x += longint'($urandom_range(0, 196608)) - 65536;
        y += longint'($urandom_range(0, 196608)) - 65536;
      end
      append_pt(x, y);
    end
  endtask

  task automatic steer_near();
    int j;
    longint cx, cy;
    j = (path_len > 0) ? $urandom_range(0, path_len - 1) : 0;
    cx = (path_len > 0) ? path_x[j] : 0;
    cy = (path_len > 0) ? path_y[j] : 0;
    cx += longint'($urandom_range(0, 262144)) - 131072;
    cy += longint'($urandom_range(0, 262144)) - 131072;
    send_item(CMD_STEER, $urandom, $urandom, 32'(cx), 32'(cy), rand_heading(),
              16'($urandom));
  endtask

  task automatic noise_item();
    logic [1:0] c;
    c = ($urandom_range(0, 1) != 0) ? CMD_UNUSED : CMD_STEER;
    send_item(c, $urandom, $urandom, $urandom, $urandom, rand_heading(), 16'($urandom));
  endtask

  initial begin
    int next_cfg;
    int phase;
    bit paused;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_AXLE;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_CLEAR;
    in_ch.waypoint_x  <= '0;
    in_ch.waypoint_y  <= '0;
    in_ch.car_x       <= '0;
    in_ch.car_y       <= '0;
    in_ch.car_heading <= '0;
    in_ch.car_speed   <= '0;
    idle_cycles = 0;
    sent = 0;
    busy_stretch = 0;
    path_len = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    clear_path();
    send_item(CMD_STEER, 0, 0, 32'sh7fffffff, 32'sh80000000, 16'sd25736, 16'sh7fff);
    send_item(CMD_UNUSED, '1, '1, '1, '1, 16'sd25736, '1);
    append_pt(64'sd2147483647, 64'sd2147483647);
    send_item(CMD_STEER, 0, 0, 32'sh80000000, 32'sh80000000, -16'sd25736, 16'sh8000);
    send_item(CMD_STEER, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 16'sd0, 16'sd0);
    append_pt(-64'sd2147483648, -64'sd2147483648);
    send_item(CMD_STEER, 0, 0, 0, 0, 16'sd12868, 16'sd256);
    append_pt(-64'sd2147483648, -64'sd2147483648);
    send_item(CMD_STEER, 0, 0, 32'sh80000000, 32'sh7fffffff, -16'sd12868, -16'sd1);
    send_item(CMD_UNUSED, 0, 0, 0, 0, 16'sd0, 16'sd0);
    clear_path();
    append_pt(0, 0);
    append_pt(65536, 0);
    append_pt(131072, 65536);
    send_item(CMD_STEER, 0, 0, 32'sd70000, -32'sd30000, 16'sd0, 16'sd0);
    send_item(CMD_STEER, 0, 0, 32'sd70000, 32'sd90000, 16'sd25736, 16'sd1);
    clear_path();
    send_item(CMD_STEER, 0, 0, 0, 0, 16'sd0, 16'sd0);

    // random
    set_regs(0, 0, 0);
    phase = 1;
    next_cfg = 300;
    paused = 0;
    while (sent < N_ITEMS) begin
      busy_stretch = (sent >= 500 && sent < 650);
      if (sent >= next_cfg) begin
        case (phase)
          1: set_regs(1310720, 32767, 65535);
          2: set_regs($urandom_range(0, 1310720), $urandom_range(0, 32767),
                      $urandom_range(0, 65535));
          default: set_regs(163840, 256, 256);
        endcase
        phase++;
        next_cfg += 300;
      end
      if (!paused && sent >= 800) begin
        drain();
        paused = 1;
      end
      case ($urandom_range(0, 19))
        0: begin
          build_path(258 + $urandom_range(0, 3));
          repeat (3) steer_near();
        end
        1, 2: repeat ($urandom_range(1, 4)) noise_item();
        3: begin
          build_path($urandom_range(1, 2));
          repeat ($urandom_range(2, 5)) steer_near();
        end
        default: begin
          build_path($urandom_range(1, ($urandom_range(0, 4) == 0) ? 100 : 40));
          repeat ($urandom_range(3, 15)) steer_near();
        end
      endcase
    end

    drain();
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ssc_pkg.sv
rtl/ssc_if.sv
rtl/ssc_path_mem.sv
rtl/ssc_cordic.sv
rtl/stanley_steering_controller.sv
tb/ssc_checker.sv
tb/tb_top.sv
